[design/hng_pkg.sv]
package hng_pkg;

	localparam int MAX_SIDE  = 1024;
	localparam int SIDE_W    = 11;
	localparam int IDX_W     = $clog2(MAX_SIDE);
	localparam int H_W       = 16;
	localparam int S_W       = 19;                 // signed slope sums
	localparam int SQ_W      = 36;                 // one square
	localparam int LEN_W     = 37;                 // sum of squares plus z term
	localparam int RAD_W     = LEN_W + 16;         // radicand, length scaled by 2^16
	localparam int ROOT_W    = 27;                 // floor(sqrt) of the radicand
	localparam int NUM_W     = 41;                 // (magnitude << 22) + root/2
	localparam int Q_W       = 16;
	localparam int ROOT_STEPS = RAD_W / 2 + 1;
	localparam int DIV_STEPS  = Q_W;
	localparam int CNT_W      = 5;

	localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(256);
	localparam logic [SIDE_W-1:0] SIDE_MIN   = SIDE_W'(3);
	localparam logic signed [H_W-1:0] ONE_Q14 = 16'sd16384;
	localparam logic [LEN_W-1:0] Z_SQ = LEN_W'(2048 * 2048);
	localparam logic [17:0] Z_MAG = 18'd2048;

	typedef enum logic [1:0] {
		COMP_X = 2'd0,
		COMP_Y = 2'd1,
		COMP_Z = 2'd2
	} comp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_SQUARE,
		ST_ROOT_INIT,
		ST_ROOT,
		ST_DIV_INIT,
		ST_DIV,
		ST_DIV_STORE
	} state_t;

	typedef struct packed {
		logic       in_ready;
		logic       update;
		logic       square;
		logic       root_init;
		logic       root_step;
		logic       div_init;
		logic       div_step;
		logic       div_store;
		comp_t      comp;
		logic       out_load;
		logic [1:0] slot;
	} cmd_t;

	typedef struct packed {
		logic       in_valid;
		logic       calc;
		logic [3:0] slot_en;
		logic       out_free;
	} status_t;

endpackage

[design/hng_ifs.sv]
interface hng_in_if;
	logic valid;
	logic ready;
	logic signed [15:0] height;
	modport source(output valid, output height, input ready);
	modport sink(input valid, input height, output ready);
endinterface

interface hng_out_if;
	logic valid;
	logic ready;
	logic [9:0] row;
	logic [9:0] col;
	logic signed [15:0] normal_x;
	logic signed [15:0] normal_y;
	logic signed [15:0] normal_z;
	logic last;
	modport source(output valid, output row, output col, output normal_x,
		output normal_y, output normal_z, output last, input ready);
	modport sink(input valid, input row, input col, input normal_x,
		input normal_y, input normal_z, input last, output ready);
endinterface

[design/hng_ram.sv]
module hng_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[design/hng_ctrl.sv]
module hng_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  hng_pkg::status_t stat,
	output hng_pkg::cmd_t    cmd
);
	import hng_pkg::*;

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	comp_t comp_q, comp_d;
	logic [1:0] slot_q, slot_d;
	logic emit_q, emit_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			comp_q  <= COMP_X;
			slot_q  <= '0;
			emit_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			comp_q  <= comp_d;
			slot_q  <= slot_d;
			emit_q  <= emit_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		comp_d  = comp_q;
		slot_d  = slot_q;
		emit_d  = emit_q;
		cmd     = '0;
		cmd.comp = comp_q;
		cmd.slot = slot_q;
		if (emit_q) begin
			// walk the four result slots, one beat for each enabled slot
			if (!stat.slot_en[slot_q] || stat.out_free) begin
				cmd.out_load = stat.slot_en[slot_q];
				if (slot_q == 2'd3) begin
					emit_d  = 1'b0;
					state_d = ST_IDLE;
				end else begin
					slot_d = slot_q + 2'd1;
				end
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					cmd.in_ready = 1'b1;
					if (stat.in_valid) begin
						state_d = ST_READ;
					end
				end
				ST_READ: begin
					cmd.update = 1'b1;
					slot_d = '0;
					if (stat.calc) begin
						state_d = ST_SQUARE;
					end else begin
						emit_d = 1'b1;
					end
				end
				ST_SQUARE: begin
					cmd.square = 1'b1;
					state_d = ST_ROOT_INIT;
				end
				ST_ROOT_INIT: begin
					cmd.root_init = 1'b1;
					cnt_d   = '0;
					state_d = ST_ROOT;
				end
				ST_ROOT: begin
					cmd.root_step = 1'b1;
					cnt_d = cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(ROOT_STEPS - 1)) begin
						comp_d  = COMP_X;
						state_d = ST_DIV_INIT;
					end
				end
				ST_DIV_INIT: begin
					cmd.div_init = 1'b1;
					cnt_d   = '0;
					state_d = ST_DIV;
				end
				ST_DIV: begin
					cmd.div_step = 1'b1;
					cnt_d = cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						state_d = ST_DIV_STORE;
					end
				end
				ST_DIV_STORE: begin
					cmd.div_store = 1'b1;
					unique case (comp_q)
						COMP_X: begin
							comp_d  = COMP_Y;
							state_d = ST_DIV_INIT;
						end
						COMP_Y: begin
							comp_d  = COMP_Z;
							state_d = ST_DIV_INIT;
						end
						default: begin
							slot_d = '0;
							emit_d = 1'b1;
						end
					endcase
				end
				default: state_d = ST_IDLE;
			endcase
		end
	end
endmodule

[design/hng_dp.sv]
module hng_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [hng_pkg::SIDE_W-1:0]  cfg_data,
	input  hng_pkg::cmd_t               cmd,
	output hng_pkg::status_t            stat,
	hng_in_if.sink                      in_ch,
	hng_out_if.source                   out_ch
);
	import hng_pkg::*;

	logic [SIDE_W-1:0] side_q, side_n;
	logic [IDX_W-1:0]  row_q, col_q, row_eff, col_eff, nm1;
	logic [IDX_W-1:0]  r_s1, c_s1, nm1_s1;
	logic signed [H_W-1:0] hb_s1;
	logic signed [H_W-1:0] w00_q, w01_q, w10_q, w11_q, w20_q, w21_q;
	logic [H_W-1:0] up_rd, mid_rd;
	logic signed [H_W-1:0] ht, hm;
	logic signed [S_W-1:0] sx_c, sy_c, sx_q, sy_q;
	logic signed [2*S_W-1:0] px, py;
	logic [SQ_W-1:0] sqx_q, sqy_q;
	logic [RAD_W-1:0] v_q, res_q, bit_q;
	logic [RAD_W:0] trial;
	logic [ROOT_W-1:0] root;
	logic [17:0] mag;
	logic neg;
	logic [NUM_W-1:0] numer;
	logic [ROOT_W:0] rem_q, rem_t;
	logic [Q_W-1:0] nlow_q, q_q, q_sat;
	logic signed [H_W-1:0] nx_q, ny_q, nz_q, n_val;
	logic calc_q;
	logic [3:0] en_q;
	logic out_v_q;

	// clamp side and counters
	always_comb begin
		priority if (side_q < SIDE_MIN) side_n = SIDE_MIN;
		else if (side_q > SIDE_W'(MAX_SIDE)) side_n = SIDE_W'(MAX_SIDE);
		else side_n = side_q;
		nm1 = IDX_W'(side_n - SIDE_W'(1));
		row_eff = ({1'b0, row_q} >= side_n) ? nm1 : row_q;
		col_eff = ({1'b0, col_q} >= side_n) ? nm1 : col_q;
	end

	hng_ram #(.WIDTH(H_W), .DEPTH(MAX_SIDE)) u_upper (
		.clk(clk), .we(cmd.update), .waddr(c_s1), .wdata(mid_rd),
		.raddr(col_eff), .rdata(up_rd)
	);
	hng_ram #(.WIDTH(H_W), .DEPTH(MAX_SIDE)) u_middle (
		.clk(clk), .we(cmd.update), .waddr(c_s1), .wdata(hb_s1),
		.raddr(col_eff), .rdata(mid_rd)
	);

	assign ht = up_rd;
	assign hm = mid_rd;

	always_comb begin
		sx_c = S_W'(w00_q) - S_W'(w20_q) - (S_W'(w21_q) <<< 1) - S_W'(hb_s1)
			+ S_W'(ht) + (S_W'(w01_q) <<< 1);
		sy_c = S_W'(w00_q) + (S_W'(w10_q) <<< 1) + S_W'(w20_q) - S_W'(hb_s1)
			- (S_W'(hm) <<< 1) - S_W'(ht);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= SIDE_RESET;
			row_q  <= '0;
			col_q  <= '0;
			w00_q <= '0; w01_q <= '0; w10_q <= '0;
			w11_q <= '0; w20_q <= '0; w21_q <= '0;
		end else if (cfg_we) begin
			side_q <= cfg_data;
			row_q  <= '0;
			col_q  <= '0;
			w00_q <= '0; w01_q <= '0; w10_q <= '0;
			w11_q <= '0; w20_q <= '0; w21_q <= '0;
		end else if (cmd.update) begin
			w00_q <= w01_q; w01_q <= ht;
			w10_q <= w11_q; w11_q <= hm;
			w20_q <= w21_q; w21_q <= hb_s1;
			if (c_s1 == nm1_s1) begin
				col_q <= '0;
				row_q <= (r_s1 == nm1_s1) ? '0 : r_s1 + IDX_W'(1);
			end else begin
				col_q <= c_s1 + IDX_W'(1);
			end
		end
	end

	// latch the accepted beat; on update, register the slopes and slot enables
	always_ff @(posedge clk) begin
		if (cmd.in_ready && in_ch.valid) begin
			hb_s1  <= in_ch.height;
			r_s1   <= row_eff;
			c_s1   <= col_eff;
			nm1_s1 <= nm1;
		end
		if (cmd.update) begin
			sx_q   <= sx_c;
			sy_q   <= sy_c;
			calc_q <= (r_s1 >= IDX_W'(2)) && (c_s1 >= IDX_W'(2));
			en_q[0] <= (r_s1 != '0) && (c_s1 != '0);
			en_q[1] <= (r_s1 != '0) && (c_s1 == nm1_s1);
			en_q[2] <= (r_s1 == nm1_s1) && (c_s1 != '0);
			en_q[3] <= (r_s1 == nm1_s1) && (c_s1 == nm1_s1);
		end
	end

	assign px = sx_q * sx_q;
	assign py = sy_q * sy_q;
	assign trial = {1'b0, res_q} + {1'b0, bit_q};
	assign root = res_q[ROOT_W-1:0];

	always_comb begin
		unique case (cmd.comp)
			COMP_X: begin
				neg = sx_q[S_W-1];
				mag = 18'(neg ? -sx_q : sx_q);
			end
			COMP_Y: begin
				neg = sy_q[S_W-1];
				mag = 18'(neg ? -sy_q : sy_q);
			end
			default: begin
				neg = 1'b0;
				mag = Z_MAG;
			end
		endcase
		numer = {mag, 22'b0, 1'b0} >> 1;
		numer = numer + NUM_W'(root >> 1);
		rem_t = {rem_q[ROOT_W-1:0], nlow_q[Q_W-1]};
		q_sat = (q_q > Q_W'(ONE_Q14)) ? Q_W'(ONE_Q14) : q_q;
		n_val = neg ? -signed'(q_sat) : signed'(q_sat);
	end

	// squares, square root and shared divider, one bit a cycle
	always_ff @(posedge clk) begin
		if (cmd.square) begin
			sqx_q <= px[SQ_W-1:0];
			sqy_q <= py[SQ_W-1:0];
		end
		if (cmd.root_init) begin
			v_q   <= {LEN_W'(sqx_q) + LEN_W'(sqy_q) + Z_SQ, 16'b0};
			res_q <= '0;
			bit_q <= RAD_W'(1) << (2 * (ROOT_STEPS - 1));
		end else if (cmd.root_step) begin
			if ({1'b0, v_q} >= trial) begin
				v_q   <= v_q - trial[RAD_W-1:0];
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (cmd.div_init) begin
			rem_q  <= (ROOT_W+1)'(numer[NUM_W-1:Q_W]);
			nlow_q <= numer[Q_W-1:0];
			q_q    <= '0;
		end else if (cmd.div_step) begin
			if (rem_t >= {1'b0, root}) begin
				rem_q <= rem_t - {1'b0, root};
				q_q   <= {q_q[Q_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_t;
				q_q   <= {q_q[Q_W-2:0], 1'b0};
			end
			nlow_q <= nlow_q << 1;
		end
		if (cmd.div_store) begin
			unique case (cmd.comp)
				COMP_X:  nx_q <= n_val;
				COMP_Y:  ny_q <= n_val;
				default: nz_q <= n_val;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_v_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_ch.last <= (cmd.slot == 2'd3);
			out_ch.row  <= (cmd.slot[1]) ? nm1_s1 : r_s1 - IDX_W'(1);
			out_ch.col  <= (cmd.slot == 2'd1 || cmd.slot == 2'd3) ? nm1_s1
				: c_s1 - IDX_W'(1);
			if (cmd.slot == 2'd0 && calc_q) begin
				out_ch.normal_x <= nx_q;
				out_ch.normal_y <= ny_q;
				out_ch.normal_z <= nz_q;
			end else begin
				out_ch.normal_x <= '0;
				out_ch.normal_y <= '0;
				out_ch.normal_z <= ONE_Q14;
			end
		end
	end

	assign out_ch.valid  = out_v_q;
	assign in_ch.ready   = cmd.in_ready;
	assign stat.in_valid = in_ch.valid;
	assign stat.calc     = (r_s1 >= IDX_W'(2)) && (c_s1 >= IDX_W'(2));
	assign stat.slot_en  = en_q;
	assign stat.out_free = !out_v_q || out_ch.ready;
endmodule

[design/heightmap_normal_generator_top.sv]
// Heightmap normal generator: takes a square grid of signed Q8.8 heights in
// raster order, one beat per point, and returns a Q1.14 unit normal for every
// grid point with its row, column and a last flag on the final normal of the
// frame. Border points get (0,0,1). Results trail the input by one row and
// one column, and the bottom row comes out alongside the row above it. Each
// input beat gives 0 to 4 result beats. The input is not ready again until a
// beat is done: for a beat whose window is interior, acceptance, the line
// store read, the squares, the bit-serial square root (set-up plus steps),
// three restoring divisions on the one shared divider (set-up, steps and
// store each), and the walk of the four result slots; for a border beat,
// acceptance, the read and the four-slot walk. A receiver that holds off a
// pending result beat stalls the slot walk. Writing cfg_data with cfg_we
// restarts the frame at row 0, column 0; values outside 3..1024 are clamped.
// The line stores need no clearing after reset.
module heightmap_normal_generator_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [hng_pkg::SIDE_W-1:0] cfg_data,
	hng_in_if.sink                     in_ch,
	hng_out_if.source                  out_ch
);
	import hng_pkg::*;

	cmd_t    cmd;
	status_t stat;

	// sequencer: accept, read line stores, iterate, emit result beats
	hng_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .stat(stat), .cmd(cmd)
	);

	// line stores, window, root and divider, output register
	hng_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.cmd(cmd), .stat(stat), .in_ch(in_ch), .out_ch(out_ch)
	);

`ifndef ASSERT_OFF
	// the final beat of a frame sits on the diagonal, as the bottom-right corner does
	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.last |-> out_ch.row == out_ch.col)
		else $error("last beat off the diagonal corner");

	// top and left border points carry the flat normal
	a_border_flat: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && (out_ch.row == 10'd0 || out_ch.col == 10'd0) |->
		out_ch.normal_x == 16'sd0 && out_ch.normal_y == 16'sd0
		&& out_ch.normal_z == ONE_Q14)
		else $error("border normal not flat");

	// the height component is never negative or above one
	a_z_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !out_ch.normal_z[15] && out_ch.normal_z <= ONE_Q14)
		else $error("normal_z out of range");
`endif
endmodule
